// ===== hdl/line_follow_obstacle_bypass_fsm_defines.svh =====
// ---------------------------------------------------------------------------
// Line follower assertion macros
// Shared concurrent assertion forms, sampled on clk, off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef LINE_FOLLOW_OBSTACLE_BYPASS_FSM_DEFINES_SVH
`define LINE_FOLLOW_OBSTACLE_BYPASS_FSM_DEFINES_SVH

// same-cycle implication
`define LFOB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LFOB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lfob_pkg.sv =====
// ---------------------------------------------------------------------------
// Line follower package
// Field widths, stream layout, command codes and bypass step codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfob_pkg;

    localparam int LINE_W      = 3;
    localparam int CMD_W       = 3;
    localparam int LEVEL_W     = 7;
    localparam int IN_FIELDS_W = LINE_W + 3;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = CMD_W + LEVEL_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;
    localparam int ACTIVE_BIT   = CMD_W + LEVEL_W;

    localparam int LAST_STEP = 9;
    localparam int MODE_W    = LAST_STEP + 1;

    localparam logic [LEVEL_W-1:0] DRIVE_LEVEL_RST = 7'd85;

    typedef enum logic [CMD_W-1:0] {
        CMD_HOLD         = 3'd0,
        CMD_FORWARD      = 3'd1,
        CMD_LEFT         = 3'd2,
        CMD_RIGHT        = 3'd3,
        CMD_ROTATE_RIGHT = 3'd4
    } cmd_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_FOLLOW = 10'b00_0000_0001,
        MODE_STEP1  = 10'b00_0000_0010,
        MODE_STEP2  = 10'b00_0000_0100,
        MODE_STEP3  = 10'b00_0000_1000,
        MODE_STEP4  = 10'b00_0001_0000,
        MODE_STEP5  = 10'b00_0010_0000,
        MODE_STEP6  = 10'b00_0100_0000,
        MODE_STEP7  = 10'b00_1000_0000,
        MODE_STEP8  = 10'b01_0000_0000,
        MODE_STEP9  = 10'b10_0000_0000
    } mode_t;

    typedef struct packed {
        logic              side_clear;
        logic              left_clear;
        logic              front_clear;
        logic [LINE_W-1:0] line_pattern;
    } sample_t;

    function automatic cmd_t step_cmd(input mode_t step);
        cmd_t c;
        case (step)
            MODE_STEP1: c = CMD_ROTATE_RIGHT;
            MODE_STEP2: c = CMD_FORWARD;
            MODE_STEP3: c = CMD_LEFT;
            MODE_STEP4: c = CMD_FORWARD;
            MODE_STEP5: c = CMD_FORWARD;
            MODE_STEP6: c = CMD_LEFT;
            MODE_STEP7: c = CMD_FORWARD;
            MODE_STEP8: c = CMD_FORWARD;
            MODE_STEP9: c = CMD_RIGHT;
            default:    c = CMD_HOLD;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/line_follow_obstacle_bypass_fsm.sv =====
// ---------------------------------------------------------------------------
// Line follower with obstacle bypass
// One sensor item in, one motor command item out; follow and bypass modes.
//
//   channel   dir  tdata fields (low bit up)
//   s_axis    in   line_pattern[2:0], front_clear[3], left_clear[4], side_clear[5]
//   m_axis    out  command[2:0], level[9:3], bypass_active[10], zero pad
//   cfg       in   drive_level, written when cfg_we is high
//
// One item per cycle while m_axis is not stalled; an accepted item passes
// through the input register and then the result register to m_axis; mode and turn
// memory update as an item moves into the result register.
// Reset gives follow mode, right turn when lost and drive level 85.
// A stall on m_axis holds both stages; s_axis_tready drops only when both are full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_follow_obstacle_bypass_fsm (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lfob_pkg::LEVEL_W-1:0]      cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // line_pattern[2:0], front_clear[3], left_clear[4], side_clear[5], zero pad
    input  logic [lfob_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // command[2:0], level[9:3], bypass_active[10], zero pad
    output logic [lfob_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    import lfob_pkg::*;

    logic [LEVEL_W-1:0] drive_level_reg;
    logic               in_valid_reg, in_valid_next;
    sample_t            in_data_reg;
    logic               out_valid_reg, out_valid_next;
    cmd_t               out_cmd_reg;
    logic [LEVEL_W-1:0] out_level_reg;
    logic               out_active_reg;
    mode_t              mode_reg, mode_next;
    logic               turn_mem_reg, turn_mem_next;

    logic               out_load;
    logic               advance;
    cmd_t               cmd_next;
    logic               active_next;
    logic [MODE_W-1:0]  holds;
    logic [MODE_W-1:0]  start;
    logic [MODE_W-1:0]  reach;
    logic [MODE_W-1:0]  elig;
    logic [MODE_W-1:0]  pick;
    logic               in_bypass;

    assign out_load       = !out_valid_reg || m_axis_tready;
    assign advance        = in_valid_reg && out_load;
    assign s_axis_tready  = !in_valid_reg || out_load;
    assign in_valid_next  = s_axis_tready ? s_axis_tvalid : in_valid_reg;
    assign out_valid_next = out_load ? in_valid_reg : out_valid_reg;

    always_comb
    begin
        holds    = '0;
        holds[1] = !(in_data_reg.left_clear && !in_data_reg.side_clear);
        holds[2] = !in_data_reg.side_clear;
        holds[3] = in_data_reg.left_clear;
        holds[4] = in_data_reg.side_clear;
        holds[5] = !in_data_reg.side_clear;
        holds[6] = in_data_reg.left_clear;
        holds[7] = in_data_reg.side_clear;
        holds[8] = (in_data_reg.line_pattern == '0);
        holds[9] = !in_data_reg.left_clear || !in_data_reg.side_clear;
    end

    always_comb
    begin
        in_bypass = |mode_reg[MODE_W-1:1];
        if (in_bypass)
            start = mode_reg;
        else if (!in_data_reg.front_clear)
            start = MODE_STEP1;
        else
            start = '0;
        reach    = '0;
        for (int i = 1; i < MODE_W; i++)
        begin
            reach[i] = reach[i-1] | start[i];
        end
        elig = reach & holds;
        pick = elig & (~elig + MODE_W'(1));
    end

    always_comb
    begin
        mode_next     = mode_reg;
        turn_mem_next = turn_mem_reg;
        cmd_next      = CMD_HOLD;
        active_next   = 1'b0;
        if (in_bypass || !in_data_reg.front_clear)
        begin
            if (|pick)
            begin
                mode_next   = mode_t'(pick);
                cmd_next    = step_cmd(mode_t'(pick));
                active_next = 1'b1;
            end
            else
            begin
                mode_next = MODE_FOLLOW;
            end
        end
        else
        begin
            mode_next = MODE_FOLLOW;
            case (in_data_reg.line_pattern)
                3'd1, 3'd3:
                begin
                    cmd_next      = CMD_LEFT;
                    turn_mem_next = 1'b1;
                end
                3'd4, 3'd6:
                begin
                    cmd_next      = CMD_RIGHT;
                    turn_mem_next = 1'b0;
                end
                3'd2, 3'd5:
                begin
                    cmd_next = CMD_FORWARD;
                end
                default:
                begin
                    cmd_next = turn_mem_reg ? CMD_LEFT : CMD_RIGHT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_level_reg <= DRIVE_LEVEL_RST;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            mode_reg        <= MODE_FOLLOW;
            turn_mem_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                drive_level_reg <= cfg_wdata;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                mode_reg     <= mode_next;
                turn_mem_reg <= turn_mem_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_data_reg <= sample_t'(s_axis_tdata[IN_FIELDS_W-1:0]);
        if (advance)
        begin
            out_cmd_reg    <= cmd_next;
            out_level_reg  <= drive_level_reg;
            out_active_reg <= active_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_active_reg, out_level_reg, out_cmd_reg};

endmodule

// ===== hdl/lfob_checker.sv =====
// ---------------------------------------------------------------------------
// Line follower port checker
// Checks the result stream of the line follower over time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "line_follow_obstacle_bypass_fsm_defines.svh"

module lfob_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [lfob_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import lfob_pkg::*;

    logic [CMD_W-1:0] out_cmd;
    logic             out_active;

    assign out_cmd    = m_axis_tdata[CMD_W-1:0];
    assign out_active = m_axis_tdata[ACTIVE_BIT];

    `LFOB_ASSERT_NXT(a_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "item dropped while stalled")
    `LFOB_ASSERT_IMP(a_cmd_legal, m_axis_tvalid, out_cmd <= CMD_ROTATE_RIGHT, "illegal command code")
    `LFOB_ASSERT_IMP(a_bypass_moves, m_axis_tvalid && out_active, out_cmd != CMD_HOLD, "hold given during bypass")
    `LFOB_ASSERT_IMP(a_rotate_bypass, m_axis_tvalid && out_cmd == CMD_ROTATE_RIGHT, out_active, "rotate outside bypass")

endmodule

bind line_follow_obstacle_bypass_fsm lfob_checker u_lfob_checker (.*);

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// Line follower with obstacle bypass: stream testbench
// Drives sensor items into line_follow_obstacle_bypass_fsm with random gaps
// and output stalls. A local mirror of the follow and bypass logic predicts
// each motor command item, and a monitor compares the commands field by field.
// Covers the follow table, every bypass step with fall-through, drive levels
// of 0, 100 and random values between, and a long random course.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import lfob_pkg::*;

    localparam int FOLLOW_MODE = 0;
    localparam int IDLE_PCT    = 18;
    localparam int REPORT_MAX  = 10;

    typedef struct {
        cmd_t               command;
        logic [LEVEL_W-1:0] level;
        logic               active;
    } motor_cmd_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [LEVEL_W-1:0]     cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // line_pattern[2:0], front_clear[3], left_clear[4], side_clear[5], zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // command[2:0], level[9:3], bypass_active[10], zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    motor_cmd_t         pending_cmds[$];
    int                 bypass_step;
    logic               lost_turn_left;
    logic [LEVEL_W-1:0] drive_level_mirror;
    logic               calm = 1'b0;

    int items_sent;
    int cmds_seen;
    int bypass_entries;
    int bypass_exits;
    int level_writes;
    int mismatches;

    line_follow_obstacle_bypass_fsm dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic sample_t make_sample(input int line, input bit front,
                                            input bit left, input bit side);
        sample_t s;
        s.line_pattern = LINE_W'(line);
        s.front_clear  = front;
        s.left_clear   = left;
        s.side_clear   = side;
        return s;
    endfunction

    function automatic bit step_holds(input int step, input sample_t s,
                                      output cmd_t action);
        bit lc;
        bit sc;
        lc = s.left_clear;
        sc = s.side_clear;
        case (step)
            1:       begin action = CMD_ROTATE_RIGHT; return !(lc && !sc);    end
            2:       begin action = CMD_FORWARD;      return !sc;             end
            3:       begin action = CMD_LEFT;         return lc;              end
            4:       begin action = CMD_FORWARD;      return sc;              end
            5:       begin action = CMD_FORWARD;      return !sc;             end
            6:       begin action = CMD_LEFT;         return lc;              end
            7:       begin action = CMD_FORWARD;      return sc;              end
            8:       begin action = CMD_FORWARD;      return s.line_pattern == 0; end
            9:       begin action = CMD_RIGHT;        return !lc || !sc;      end
            default: begin action = CMD_HOLD;         return 1'b0;            end
        endcase
    endfunction

    function automatic cmd_t follow_line(input logic [LINE_W-1:0] line);
        cmd_t remembered;
        remembered = lost_turn_left ? CMD_LEFT : CMD_RIGHT;
        case (line)
            3'd1, 3'd3:
            begin
                lost_turn_left = 1'b1;
                return CMD_LEFT;
            end
            3'd4, 3'd6:
            begin
                lost_turn_left = 1'b0;
                return CMD_RIGHT;
            end
            3'd2, 3'd5: return CMD_FORWARD;
            default:    return remembered;
        endcase
    endfunction

    function automatic motor_cmd_t next_motor_cmd(input sample_t s);
        motor_cmd_t r;
        cmd_t       action;
        r.command = CMD_HOLD;
        r.level   = drive_level_mirror;
        r.active  = 1'b0;
        action    = CMD_HOLD;
        if (bypass_step == FOLLOW_MODE)
        begin
            if (!s.front_clear)
            begin
                bypass_step = 1;
                bypass_entries++;
            end
            else
                r.command = follow_line(s.line_pattern);
        end
        if (bypass_step != FOLLOW_MODE)
        begin
            while (bypass_step <= LAST_STEP && !step_holds(bypass_step, s, action))
                bypass_step++;
            if (bypass_step > LAST_STEP)
            begin
                bypass_step = FOLLOW_MODE;
                r.command   = CMD_HOLD;
                bypass_exits++;
            end
            else
            begin
                r.command = action;
                r.active  = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin : check_cmds
        motor_cmd_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            cmds_seen++;
            if (pending_cmds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0t] unexpected command item tdata=%h", $realtime,
                             m_axis_tdata);
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (m_axis_tdata[CMD_W-1:0] !== want.command ||
                    m_axis_tdata[CMD_W +: LEVEL_W] !== want.level ||
                    m_axis_tdata[ACTIVE_BIT] !== want.active)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("[%0t] mismatch: exp cmd=%0d lvl=%0d act=%0b, got cmd=%0d lvl=%0d act=%0b",
                                 $realtime, want.command, want.level, want.active,
                                 m_axis_tdata[CMD_W-1:0], m_axis_tdata[CMD_W +: LEVEL_W],
                                 m_axis_tdata[ACTIVE_BIT]);
                end
            end
        end
    end

    task automatic send_sample(input sample_t s);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(s);
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_cmds.push_back(next_motor_cmd(s));
        items_sent++;
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_cmds.size() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_level(input logic [LEVEL_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        drive_level_mirror = value;
        level_writes++;
    endtask

    function automatic sample_t course_sample();
        sample_t s;
        s.line_pattern = LINE_W'($urandom_range(0, 7));
        s.front_clear  = $urandom_range(0, 1);
        s.left_clear   = $urandom_range(0, 1);
        s.side_clear   = $urandom_range(0, 1);
        if ($urandom_range(0, 99) < 10)
            return s;
        if (bypass_step == FOLLOW_MODE)
            s.front_clear = $urandom_range(0, 99) >= 15;
        else if ($urandom_range(0, 99) < 40)
            s.line_pattern = '0;
        return s;
    endfunction

    task automatic drive_course(input int count);
        for (int i = 0; i < count; i++)
            send_sample(course_sample());
    endtask

    task automatic test_follow_table;
        int lines[11] = '{0, 7, 1, 0, 7, 3, 2, 5, 4, 6, 0};
        foreach (lines[i])
            send_sample(make_sample(lines[i], 1'b1, 1'b1, 1'b1));
    endtask

    task automatic test_bypass_walk;
        // enter and fall past the first step, then walk every step in turn
        send_sample(make_sample(0, 1'b0, 1'b1, 1'b0));
        send_sample(make_sample(7, 1'b1, 1'b0, 1'b1));
        send_sample(make_sample(7, 1'b0, 1'b1, 1'b0));
        send_sample(make_sample(2, 1'b1, 1'b1, 1'b1));
        send_sample(make_sample(2, 1'b1, 1'b0, 1'b1));
        send_sample(make_sample(0, 1'b1, 1'b1, 1'b0));
        send_sample(make_sample(5, 1'b1, 1'b0, 1'b0));
        send_sample(make_sample(5, 1'b0, 1'b1, 1'b1));
        // enter with the first step holding, then finish from step one
        send_sample(make_sample(7, 1'b0, 1'b1, 1'b1));
        send_sample(make_sample(2, 1'b1, 1'b1, 1'b0));
        send_sample(make_sample(0, 1'b0, 1'b1, 1'b1));
        send_sample(make_sample(6, 1'b1, 1'b0, 1'b0));
        send_sample(make_sample(4, 1'b1, 1'b1, 1'b1));
        send_sample(make_sample(4, 1'b1, 1'b1, 1'b1));
    endtask

    task automatic test_drive_levels;
        logic [LEVEL_W-1:0] levels[5];
        levels = '{7'd0, 7'd100, LEVEL_W'($urandom_range(0, 100)),
                   LEVEL_W'($urandom_range(0, 100)), DRIVE_LEVEL_RST};
        foreach (levels[i])
        begin
            write_level(levels[i]);
            drive_course(60);
        end
    endtask

    task automatic test_random_course;
        drive_course(250);
        calm = 1'b1;
        drive_course(200);
        calm = 1'b0;
        drain();
        drive_course(100);
    endtask

    initial
    begin
        bypass_step        = FOLLOW_MODE;
        lost_turn_left     = 1'b0;
        drive_level_mirror = DRIVE_LEVEL_RST;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_follow_table();
        test_bypass_walk();
        test_drive_levels();
        test_random_course();

        drain();
        repeat (10) @(posedge clk);
        if (pending_cmds.size() != 0)
        begin
            mismatches++;
            $display("%0d command items never arrived", pending_cmds.size());
        end
        $display("Sent %0d sensor items, checked %0d command items, %0d level writes.",
                 items_sent, cmds_seen, level_writes);
        $display("Bypass entered %0d times and completed %0d times; %0d failures.",
                 bypass_entries, bypass_exits, mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
